@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

  // Field widths of the item and result beats
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Character codes with special handling
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Attribute after reset, also used by the clearing pass
  localparam logic [ATTR_W-1:0] ATTR_RESET = 7'h0F;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFS_W-1:0]  cursor_offset;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

  typedef logic [ATTR_W-1:0] attr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_FLUSH,
    ST_READ
  } state_t;

endpackage

@@ rtl/tcw_chan_if.sv @@
interface tcw_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/text_console_writer_core.sv @@
// Text console writer over a COLUMNS x ROWS buffer of 16-bit cells (bit 15 zero, attribute in
// bits 14..8, character in bits 7..0) held in one synchronous RAM with one write and one
// registered read port. After reset the block runs a clearing pass that fills the buffer with
// blanks of attribute 0x0F; no item is accepted during it, while the attribute register can be
// written at any time. One item is in flight at a time. A move, a newline above the last row
// and an unused op only load the result; a read returns the addressed cell, zero if out of range;
// a plain character writes one cell and a tab TAB_SPACES blank cells, one cell write per cycle.
// A newline on the last row scrolls the buffer with the RAM copying one cell per cycle; a
// deferred wrap there is detected when the next character is put and scrolls likewise first.
// A result waits in an output register, and the next item is taken in the cycle that result
// leaves.
module text_console_writer_core #(
  parameter int COLUMNS    = 80,
  parameter int ROWS       = 25,
  parameter int TAB_SPACES = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  tcw_chan_if.sink    in_if,
  tcw_chan_if.source  out_if,
  tcw_chan_if.sink    cfg_if
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int PW    = $clog2(TAB_SPACES + 1);

  // Linear cell address of a 1-based column and row
  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
    return AW'((32'(c) - 32'd1) + (32'(r) - 32'd1) * 32'(COLUMNS));
  endfunction

  // Screen buffer
  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] rd_data_r;

  // Control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              wrap_r, wrap_nxt;
  attr_t             attr_r, attr_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]     put_cnt_r, put_cnt_nxt;
  logic              after_put_r, after_put_nxt;
  logic              cp_vld_r, cp_vld_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload state
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [AW-1:0]     cp_dst_r, cp_dst_nxt;
  logic              cp_blank_r, cp_blank_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // Decode
  logic              in_ready;
  logic              accept;
  logic              in_range;
  logic              last_row;
  logic              last_col;
  logic              wrap_nl;
  logic              put_scroll;
  logic              put_done;
  logic              cnt_last;
  logic [AW:0]       scr_src;
  logic              scr_blank;
  logic [CW-1:0]     eff_col;
  logic [RW-1:0]     eff_row;
  logic              emit;
  logic [CELL_W-1:0] emit_data;

  assign in_ready   = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign accept     = in_if.valid && in_ready;
  assign in_range   = (in_if.data.col != '0) && (32'(in_if.data.col) <= COLUMNS) &&
                      (in_if.data.row != '0) && (32'(in_if.data.row) <= ROWS);
  assign last_row   = (row_r == RW'(ROWS));
  assign last_col   = (col_r == CW'(COLUMNS));
  assign wrap_nl    = wrap_r && last_col;
  assign put_scroll = wrap_nl && last_row;
  assign put_done   = (put_cnt_r == PW'(1));
  assign cnt_last   = (cnt_r == AW'(CELLS - 1));
  assign scr_src    = {1'b0, cnt_r} + (AW+1)'(COLUMNS);
  assign scr_blank  = (scr_src >= (AW+1)'(CELLS));
  assign eff_col    = wrap_nl ? CW'(1) : col_r;
  assign eff_row    = wrap_nl ? (row_r + RW'(1)) : row_r;

  assign in_if.ready  = in_ready;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_if.data.op)
            OP_PUT: begin
              if (in_if.data.char_code != CHAR_NL) state_nxt = ST_PUT;
              else if (last_row) state_nxt = ST_SCROLL;
            end
            OP_READ: state_nxt = ST_READ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PUT: begin
        if (put_scroll) state_nxt = ST_SCROLL;
        else if (put_done) state_nxt = ST_IDLE;
      end
      ST_SCROLL: begin
        if (cnt_last) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: state_nxt = after_put_r ? ST_PUT : ST_IDLE;
      ST_READ:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    wrap_nxt      = wrap_r;
    attr_nxt      = attr_r;
    cnt_nxt       = cnt_r;
    put_cnt_nxt   = put_cnt_r;
    after_put_nxt = after_put_r;
    rd_ok_nxt     = rd_ok_r;
    ch_nxt        = ch_r;
    cp_vld_nxt    = 1'b0;
    cp_dst_nxt    = cnt_r;
    cp_blank_nxt  = scr_blank;
    mem_we        = 1'b0;
    mem_waddr     = cp_dst_r;
    mem_wdata     = cp_blank_r ? {1'b0, attr_r, CHAR_SPACE} : rd_data_r;
    mem_raddr     = '0;
    emit          = 1'b0;
    emit_data     = '0;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_data_nxt  = out_data_r;

    if (cfg_if.valid) attr_nxt = cfg_if.data;

    // Write back the scroll copy in the cycle after its read
    if (cp_vld_r) mem_we = 1'b1;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = {1'b0, ATTR_RESET, CHAR_SPACE};
        cnt_nxt   = cnt_last ? '0 : cnt_r + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_if.data.op)
            OP_PUT: begin
              if (in_if.data.char_code == CHAR_NL) begin
                wrap_nxt = 1'b0;
                if (last_row) begin
                  after_put_nxt = 1'b0;
                  cnt_nxt       = '0;
                end else begin
                  col_nxt = CW'(1);
                  row_nxt = row_r + RW'(1);
                  emit    = 1'b1;
                end
              end else if (in_if.data.char_code == CHAR_TAB) begin
                ch_nxt      = CHAR_SPACE;
                put_cnt_nxt = PW'(TAB_SPACES);
              end else begin
                ch_nxt      = in_if.data.char_code;
                put_cnt_nxt = PW'(1);
              end
            end
            OP_MOVE: begin
              if (in_range) begin
                col_nxt = CW'(in_if.data.col);
                row_nxt = RW'(in_if.data.row);
              end
              emit = 1'b1;
            end
            OP_READ: begin
              rd_ok_nxt = in_range;
              if (in_range) mem_raddr = cell_addr(CW'(in_if.data.col), RW'(in_if.data.row));
            end
            default: emit = 1'b1;
          endcase
        end
      end
      ST_PUT: begin
        if (put_scroll) begin
          after_put_nxt = 1'b1;
          cnt_nxt       = '0;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = cell_addr(eff_col, eff_row);
          mem_wdata   = {1'b0, attr_r, ch_r};
          row_nxt     = eff_row;
          if (eff_col == CW'(COLUMNS)) begin
            col_nxt  = eff_col;
            wrap_nxt = 1'b1;
          end else begin
            col_nxt  = eff_col + CW'(1);
            wrap_nxt = 1'b0;
          end
          put_cnt_nxt = put_cnt_r - PW'(1);
          emit        = put_done;
        end
      end
      ST_SCROLL: begin
        mem_raddr  = scr_blank ? '0 : AW'(scr_src);
        cp_vld_nxt = 1'b1;
        cnt_nxt    = cnt_last ? '0 : cnt_r + AW'(1);
      end
      ST_FLUSH: begin
        col_nxt  = CW'(1);
        row_nxt  = RW'(ROWS);
        wrap_nxt = 1'b0;
        emit     = !after_put_r;
      end
      ST_READ: begin
        emit      = 1'b1;
        emit_data = rd_ok_r ? rd_data_r : '0;
      end
      default: ;
    endcase

    // Load the result beat with the cursor after this item
    if (emit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.cursor_col    = COL_W'(col_nxt);
      out_data_nxt.cursor_row    = ROW_W'(row_nxt);
      out_data_nxt.cursor_offset = OFS_W'(cell_addr(col_nxt, row_nxt));
      out_data_nxt.cell_data     = emit_data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      col_r       <= CW'(1);
      row_r       <= RW'(1);
      wrap_r      <= 1'b0;
      attr_r      <= ATTR_RESET;
      cnt_r       <= '0;
      put_cnt_r   <= '0;
      after_put_r <= 1'b0;
      cp_vld_r    <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      wrap_r      <= wrap_nxt;
      attr_r      <= attr_nxt;
      cnt_r       <= cnt_nxt;
      put_cnt_r   <= put_cnt_nxt;
      after_put_r <= after_put_nxt;
      cp_vld_r    <= cp_vld_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    cp_dst_r   <= cp_dst_nxt;
    cp_blank_r <= cp_blank_nxt;
    out_data_r <= out_data_nxt;
  end

  // Screen RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

endmodule
